### design/its_pkg.sv
// shared constants, codes and types for the interval timer statistics block
// no dependencies; used by the channel interfaces, the top level and the checker
package its_pkg;

  localparam int CHANNELS = 16;
  localparam int CMD_W    = 2;
  localparam int CH_W     = 4;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OPN_W    = $clog2(CHANNELS + 1);
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  // one memory word per channel
  typedef struct packed {
    logic [DATA_W-1:0] start_stamp;
    logic [DATA_W-1:0] least;
    logic [DATA_W-1:0] greatest;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] count;
    logic              roll;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_UPD,
    ST_DIV,
    ST_RESP
  } state_t;

endpackage

### design/its_if.sv
// request and result channel interfaces for the interval timer statistics block
// depends on its_pkg for field widths
interface its_in_if;
  logic                         valid;
  logic                         ready;
  logic [its_pkg::CMD_W-1:0]    cmd;
  logic [its_pkg::CH_W-1:0]     channel;
  logic [its_pkg::DATA_W-1:0]   timestamp_us;

  modport source (output valid, output cmd, output channel, output timestamp_us,
                  input ready);
  modport sink   (input valid, input cmd, input channel, input timestamp_us,
                  output ready);
endinterface

interface its_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [its_pkg::DATA_W-1:0] min_time;
  logic signed [its_pkg::DATA_W-1:0] mean_time;
  logic signed [its_pkg::DATA_W-1:0] max_time;

  modport source (output valid, output min_time, output mean_time, output max_time,
                  input ready);
  modport sink   (input valid, input min_time, input mean_time, input max_time,
                  output ready);
endinterface

### design/interval_timer_statistics_top.sv
// Multi-channel interval profiler: start, stop and query requests on a per-channel
// statistics memory (registered synchronous read), with a 32-step shared divider.
// Start writes the start stamp; stop reads, takes the duration and writes back.
// Query: result registered in ST_RESP after ST_EXEC, via ST_DIV when the mean runs
// through the bit-serial divider; one request at a time, the next taken in ST_IDLE.
// Reset (rst_n low, synchronous) clears control, opened count and per-entry valid bits.
module interval_timer_statistics_top (
  input  logic         clk,
  input  logic         rst_n,
  its_in_if.sink       in_bus,
  its_out_if.source    out_bus
);

  its_pkg::state_t state_r, state_nxt;

  logic [its_pkg::CMD_W-1:0]  cmd_r;
  logic [its_pkg::CH_W-1:0]   ch_r;
  logic [its_pkg::DATA_W-1:0] ts_r;

  its_pkg::entry_t stat_mem [its_pkg::CHANNELS];
  its_pkg::entry_t rd_r;
  logic            rd_vld_r;
  logic [its_pkg::CHANNELS-1:0] vld_r;
  logic [its_pkg::OPN_W-1:0]    opened_r;

  logic [its_pkg::DATA_W-1:0] dur_r;
  logic [its_pkg::DATA_W-1:0] res_min_r, res_max_r, res_mean_r;
  logic [its_pkg::DATA_W-1:0] dvd_r, rem_r, dsr_r;
  logic [its_pkg::STEP_W-1:0] step_r;

  logic                       out_valid_r;
  logic [its_pkg::DATA_W-1:0] out_min_r, out_mean_r, out_max_r;

  logic            in_ready;
  logic            acc;
  logic            mem_we;
  logic            out_load;
  logic            div_last;
  its_pkg::entry_t cur;
  its_pkg::entry_t wr_data;
  its_pkg::entry_t upd;
  logic [its_pkg::IDX_W-1:0]  in_addr, wr_addr;
  logic            ch_ok, opened, has_samp, need_div, extends_open;
  logic [its_pkg::DATA_W-1:0] new_sum;
  logic [its_pkg::DATA_W+1:0] diff;
  logic            qbit;

  assign acc     = in_bus.valid && in_ready;
  assign in_addr = its_pkg::IDX_W'(in_bus.channel);
  assign wr_addr = its_pkg::IDX_W'(ch_r);

  // an entry never written reads as its reset value
  assign cur = rd_vld_r ? rd_r : '0;

  assign ch_ok        = 32'(ch_r) < 32'(its_pkg::CHANNELS);
  assign opened       = ch_ok && (32'(ch_r) < 32'(opened_r));
  assign extends_open = ch_ok && !(32'(ch_r) < 32'(opened_r));
  assign has_samp     = cur.count != '0;
  assign need_div     = opened && has_samp && !cur.roll;
  assign div_last     = step_r == its_pkg::STEP_W'(its_pkg::DIV_STEPS - 1);

  // sample fold
  assign new_sum = cur.sum + dur_r;
  always_comb begin
    upd = cur;
    if (!has_samp || ($signed(dur_r) < $signed(cur.least))) begin
      upd.least = dur_r;
    end
    if (!has_samp || ($signed(dur_r) > $signed(cur.greatest))) begin
      upd.greatest = dur_r;
    end
    upd.sum  = new_sum;
    upd.roll = cur.roll | new_sum[its_pkg::DATA_W-1];
    if (cur.count != its_pkg::ALL_ONES) begin
      upd.count = cur.count + 1'b1;
    end
  end

  always_comb begin
    wr_data = upd;
    if (state_r == its_pkg::ST_EXEC) begin
      wr_data = cur;
      wr_data.start_stamp = ts_r;
    end
  end

  // restoring divider step
  assign diff = {1'b0, rem_r, dvd_r[its_pkg::DATA_W-1]} - {2'b00, dsr_r};
  assign qbit = !diff[its_pkg::DATA_W+1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      its_pkg::ST_IDLE: begin
        if (acc) state_nxt = its_pkg::ST_EXEC;
      end
      its_pkg::ST_EXEC: begin
        case (cmd_r)
          its_pkg::CMD_STOP:  state_nxt = opened ? its_pkg::ST_UPD : its_pkg::ST_IDLE;
          its_pkg::CMD_QUERY: state_nxt = need_div ? its_pkg::ST_DIV : its_pkg::ST_RESP;
          default:            state_nxt = its_pkg::ST_IDLE;
        endcase
      end
      its_pkg::ST_UPD: begin
        state_nxt = its_pkg::ST_IDLE;
      end
      its_pkg::ST_DIV: begin
        if (div_last) state_nxt = its_pkg::ST_RESP;
      end
      its_pkg::ST_RESP: begin
        if (!out_valid_r || out_bus.ready) state_nxt = its_pkg::ST_IDLE;
      end
      default: state_nxt = its_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      its_pkg::ST_IDLE: in_ready = 1'b1;
      its_pkg::ST_EXEC: mem_we   = (cmd_r == its_pkg::CMD_START) && ch_ok;
      its_pkg::ST_UPD:  mem_we   = 1'b1;
      its_pkg::ST_RESP: out_load = !out_valid_r || out_bus.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= its_pkg::ST_IDLE;
      vld_r       <= '0;
      opened_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) vld_r[wr_addr] <= 1'b1;
      if (state_r == its_pkg::ST_EXEC && cmd_r == its_pkg::CMD_START && extends_open) begin
        opened_r <= its_pkg::OPN_W'(32'(ch_r) + 32'd1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // statistics memory, one write and one registered read per cycle, the read on request acceptance
  always_ff @(posedge clk) begin
    if (mem_we) stat_mem[wr_addr] <= wr_data;
    if (acc) begin
      rd_r     <= stat_mem[in_addr];
      rd_vld_r <= vld_r[in_addr];
      cmd_r    <= in_bus.cmd;
      ch_r     <= in_bus.channel;
      ts_r     <= in_bus.timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      its_pkg::ST_EXEC: begin
        dur_r      <= ts_r - cur.start_stamp;
        res_min_r  <= (opened && has_samp) ? cur.least : its_pkg::ALL_ONES;
        res_max_r  <= (opened && has_samp) ? cur.greatest : its_pkg::ALL_ONES;
        res_mean_r <= its_pkg::ALL_ONES;
        dvd_r      <= cur.sum;
        rem_r      <= '0;
        dsr_r      <= cur.count;
        step_r     <= '0;
      end
      its_pkg::ST_DIV: begin
        rem_r  <= qbit ? diff[its_pkg::DATA_W-1:0]
                       : {rem_r[its_pkg::DATA_W-2:0], dvd_r[its_pkg::DATA_W-1]};
        dvd_r  <= {dvd_r[its_pkg::DATA_W-2:0], qbit};
        step_r <= step_r + 1'b1;
        if (div_last) res_mean_r <= {dvd_r[its_pkg::DATA_W-2:0], qbit};
      end
      default: ;
    endcase
    if (out_load) begin
      out_min_r  <= res_min_r;
      out_mean_r <= res_mean_r;
      out_max_r  <= res_max_r;
    end
  end

  assign in_bus.ready      = in_ready;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.min_time  = $signed(out_min_r);
  assign out_bus.mean_time = $signed(out_mean_r);
  assign out_bus.max_time  = $signed(out_max_r);

endmodule

### design/its_checker.sv
// port-level checks for interval_timer_statistics_top, attached by bind
// depends on its_pkg and on the top level's channel interfaces
module its_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [its_pkg::DATA_W-1:0] out_min_time,
  input logic [its_pkg::DATA_W-1:0] out_mean_time,
  input logic [its_pkg::DATA_W-1:0] out_max_time
);

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time: an accepted request holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a result is only launched from the busy response step
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result launched while idle");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_time)
      && $stable(out_mean_time) && $stable(out_max_time))
    else $error("stalled result changed");

endmodule

bind interval_timer_statistics_top its_checker u_its_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_min_time  (out_bus.min_time),
  .out_mean_time (out_bus.mean_time),
  .out_max_time  (out_bus.max_time)
);
